[design/fss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types, score constants and character helpers of the fuzzy
// subsequence scorer.
// ----------------------------------------------------------------------------
package fss_pkg;

   // character and result widths
   localparam int CHAR_W  = 16;
   localparam int SCORE_W = 12;
   localparam int COST_W  = 4;

   // item command codes
   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_CHAR   = 2'd2
   } cmd_type;

   // score weights
   localparam int MATCH_PTS  = 12;
   localparam int ADJ_PTS    = 18;
   localparam int SEP_PTS    = 14;
   localparam int GAP_MAX    = 12;
   localparam int LEAD_MAX   = 30;
   localparam int EXACT_PTS  = 220;
   localparam int PREFIX_PTS = 110;
   localparam int SUBSTR_PTS = 65;
   localparam int SCORE_MAX  = 2047;
   localparam int SCORE_MIN  = -1024;

   // result queue sizing: slack covers the items still in the pipeline
   localparam int RSP_DEPTH = 4;
   localparam int RSP_AW    = 2;
   localparam int RSP_CW    = 3;
   localparam int RSP_SLACK = 3;

   // ascii characters that count as word separators, and the case-folding constants
   localparam logic [CHAR_W-1:0] CH_SLASH = 16'h002F;
   localparam logic [CHAR_W-1:0] CH_UNDER = 16'h005F;
   localparam logic [CHAR_W-1:0] CH_DASH  = 16'h002D;
   localparam logic [CHAR_W-1:0] CH_DOT   = 16'h002E;
   localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
   localparam logic [CHAR_W-1:0] CH_UP_A  = 16'h0041;
   localparam logic [CHAR_W-1:0] CH_UP_Z  = 16'h005A;
   localparam logic [CHAR_W-1:0] CH_CASE  = 16'h0020;

   // completion bonus kinds
   typedef enum logic [1:0] {
      BONUS_NONE   = 2'd0,
      BONUS_SUBSTR = 2'd1,
      BONUS_PREFIX = 2'd2,
      BONUS_EXACT  = 2'd3
   } bonus_type;

   // per-item control into every cell
   typedef struct packed {
      logic restart;
      logic append;
      logic step;
      logic last;
   } cell_ctrl_type;

   // per-item status out of one cell
   typedef struct packed {
      logic match;
      logic prefix_fail;
      logic hit;
   } cell_stat_type;

   // flags handed from the cell row to the scoring stage
   typedef struct packed {
      logic restart;
      logic step;
      logic last;
      logic sep;
      logic match;
      logic prefix_fail;
      logic hit;
   } s1_flags_type;

   // one result item, score in the low bits
   typedef struct packed {
      logic                 matched;
      logic [SCORE_W-1:0]   score;
   } rsp_type;

   // ascii-only case folding
   function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= CH_UP_A && c <= CH_UP_Z) begin
         r = c + CH_CASE;
      end
      return r;
   endfunction

   function automatic logic is_sep(input logic [CHAR_W-1:0] c);
      return (c == CH_SLASH) || (c == CH_UNDER) || (c == CH_DASH) ||
             (c == CH_DOT) || (c == CH_SPACE);
   endfunction

endpackage

`default_nettype wire

[design/fss_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fss_cell
// One query position: holds its query character, the greedy match token
// and the shift-and window bit, and passes both on to the next cell.
// ----------------------------------------------------------------------------
module fss_cell import fss_pkg::*; #(
   parameter int IDX = 0,
   parameter int QW  = 6,
   parameter int PW  = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  cell_ctrl_type       ctrl,
   input  logic [CHAR_W-1:0]   char_in,
   input  logic [QW-1:0]       qlen,
   input  logic [PW-1:0]       pos,
   input  logic                token_in,
   input  logic                window_in,
   output logic                token_out,
   output logic                token_state,
   output logic                window_out,
   output cell_stat_type       stat
);

   logic [CHAR_W-1:0] q_ff;
   logic              t_ff, t_in;
   logic              w_ff, w_in;
   logic              active, tail, write_here, at_pos, eq, match, w_next;

   // position decode against this cell's index
   assign active     = 32'(qlen) > IDX;
   assign tail       = 32'(qlen) == IDX + 1;
   assign write_here = 32'(qlen) == IDX;
   assign at_pos     = 32'(pos) == IDX;
   assign eq         = char_in == q_ff;

   // greedy match and shift-and window update
   assign match  = ctrl.step & t_ff & eq & active;
   assign w_next = window_in & eq & active;

   assign token_out   = match;
   assign token_state = t_ff;
   assign window_out  = w_ff;

   assign stat.match       = match;
   assign stat.prefix_fail = ctrl.step & at_pos & active & ~eq;
   assign stat.hit         = ctrl.step & w_next & tail;

   // next token and window
   always_comb begin
      t_in = t_ff;
      w_in = w_ff;
      priority if (ctrl.restart || (ctrl.step && ctrl.last)) begin
         t_in = (IDX == 0);
         w_in = 1'b0;
      end else if (ctrl.step) begin
         t_in = (t_ff & ~match) | token_in;
         w_in = w_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff <= (IDX == 0);
         w_ff <= 1'b0;
      end else begin
         t_ff <= t_in;
         w_ff <= w_in;
      end
   end

   // query character store
   always_ff @(posedge clock) begin
      if (ctrl.append && write_here) begin
         q_ff <= char_in;
      end
   end

endmodule

`default_nettype wire

[design/fss_score.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fss_score
// Running score of one candidate: match bonuses and gap costs per item,
// then the end-of-candidate penalties, completion bonus and saturation.
// ----------------------------------------------------------------------------
module fss_score import fss_pkg::*; #(
   parameter int MAX_QUERY = 32,
   parameter int MAX_TEXT  = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  s1_flags_type                   flags,
   input  logic [$clog2(MAX_TEXT)-1:0]    pos,
   input  logic [$clog2(MAX_TEXT+1)-1:0]  len,
   input  logic [$clog2(MAX_QUERY+1)-1:0] qlen,
   output logic                           res_valid,
   output rsp_type                        res
);

   localparam int QW  = $clog2(MAX_QUERY + 1);
   localparam int PW  = $clog2(MAX_TEXT);
   localparam int PW1 = PW + 1;
   localparam int TW  = $clog2(MAX_TEXT + 1);
   localparam int RW  = QW + 7;
   localparam int CW  = (TW > QW) ? TW : QW;
   localparam int M1  = (RW > TW) ? RW : TW;
   localparam int SW  = ((M1 > SCORE_W) ? M1 : SCORE_W) + 2;

   logic [QW-1:0]        mcount_ff, mcount_in, mcount_upd;
   logic [PW-1:0]        prev_ff, prev_in, prev_upd;
   logic [PW-1:0]        first_ff, first_in, first_upd;
   logic signed [RW-1:0] run_ff, run_in, run_upd;
   logic                 psep_ff, psep_in;
   logic                 pfx_ff, pfx_in, pfx_upd;
   logic                 seen_ff, seen_in, seen_upd;

   logic                 f_valid_ff, f_valid_in;
   logic signed [RW-1:0] f_run_ff;
   logic [PW-1:0]        f_first_ff;
   logic [TW-1:0]        f_len_ff;
   bonus_type            f_bonus_ff, f_bonus_in;
   logic                 f_empty_ff, f_fail_ff;

   logic                 first_hit, adj, sep_hit;
   logic [PW-1:0]        gap;
   logic [COST_W-1:0]    cost;
   logic signed [RW-1:0] delta;

   // per-match score pieces
   assign first_hit = mcount_ff == '0;
   assign gap       = pos - prev_ff - PW'(1);
   assign sep_hit   = (pos == '0) || psep_ff;

   always_comb begin
      if (first_hit) begin
         adj  = pos == '0;
         cost = '0;
      end else begin
         adj  = PW1'(pos) == PW1'(prev_ff) + PW1'(1);
         cost = '0;
         if (pos > prev_ff) begin
            cost = (gap < PW'(GAP_MAX)) ? gap[COST_W-1:0] : COST_W'(GAP_MAX);
         end
      end
   end

   assign delta = RW'(MATCH_PTS) + (adj ? RW'(ADJ_PTS) : RW'(0)) +
                  (sep_hit ? RW'(SEP_PTS) : RW'(0)) - RW'(cost);

   // candidate state after this item
   always_comb begin
      mcount_upd = mcount_ff;
      prev_upd   = prev_ff;
      first_upd  = first_ff;
      run_upd    = run_ff;
      if (flags.match) begin
         mcount_upd = mcount_ff + QW'(1);
         prev_upd   = pos;
         run_upd    = run_ff + delta;
         if (first_hit) begin
            first_upd = pos;
         end
      end
      pfx_upd  = pfx_ff & ~flags.prefix_fail;
      seen_upd = seen_ff | flags.hit;
   end

   // completion bonus of a finished candidate
   always_comb begin
      priority if (pfx_upd && (CW'(len) == CW'(qlen))) begin
         f_bonus_in = BONUS_EXACT;
      end else if (pfx_upd && (CW'(len) >= CW'(qlen))) begin
         f_bonus_in = BONUS_PREFIX;
      end else if (seen_upd) begin
         f_bonus_in = BONUS_SUBSTR;
      end else begin
         f_bonus_in = BONUS_NONE;
      end
   end

   // state select: restart, step, or hold
   always_comb begin
      mcount_in  = mcount_ff;
      prev_in    = prev_ff;
      first_in   = first_ff;
      run_in     = run_ff;
      psep_in    = psep_ff;
      pfx_in     = pfx_ff;
      seen_in    = seen_ff;
      f_valid_in = 1'b0;
      priority if (flags.restart || (flags.step && flags.last)) begin
         mcount_in  = '0;
         prev_in    = '0;
         first_in   = '0;
         run_in     = '0;
         psep_in    = 1'b0;
         pfx_in     = 1'b1;
         seen_in    = 1'b0;
         f_valid_in = flags.step;
      end else if (flags.step) begin
         mcount_in = mcount_upd;
         prev_in   = prev_upd;
         first_in  = first_upd;
         run_in    = run_upd;
         psep_in   = flags.sep;
         pfx_in    = pfx_upd;
         seen_in   = seen_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mcount_ff  <= '0;
         prev_ff    <= '0;
         first_ff   <= '0;
         run_ff     <= '0;
         psep_ff    <= 1'b0;
         pfx_ff     <= 1'b1;
         seen_ff    <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         mcount_ff  <= mcount_in;
         prev_ff    <= prev_in;
         first_ff   <= first_in;
         run_ff     <= run_in;
         psep_ff    <= psep_in;
         pfx_ff     <= pfx_in;
         seen_ff    <= seen_in;
         f_valid_ff <= f_valid_in;
      end
   end

   // finished candidate record
   always_ff @(posedge clock) begin
      if (f_valid_in) begin
         f_run_ff   <= run_upd;
         f_first_ff <= first_upd;
         f_len_ff   <= len;
         f_bonus_ff <= f_bonus_in;
         f_empty_ff <= qlen == '0;
         f_fail_ff  <= mcount_upd < qlen;
      end
   end

   // final penalties, bonus and saturation
   logic signed [SW-1:0] first_s, lead_s, len8_s, bonus_s, sum_s;
   logic [SCORE_W-1:0]   sat;

   assign first_s = signed'(SW'(f_first_ff));
   assign lead_s  = (first_s < SW'(LEAD_MAX)) ? first_s : SW'(LEAD_MAX);
   assign len8_s  = signed'(SW'(f_len_ff >> 3));

   always_comb begin
      unique case (f_bonus_ff)
         BONUS_EXACT:  bonus_s = SW'(EXACT_PTS);
         BONUS_PREFIX: bonus_s = SW'(PREFIX_PTS);
         BONUS_SUBSTR: bonus_s = SW'(SUBSTR_PTS);
         default:      bonus_s = '0;
      endcase
   end

   assign sum_s = SW'(f_run_ff) - lead_s - len8_s + bonus_s;

   always_comb begin
      priority if (sum_s > SW'(SCORE_MAX)) begin
         sat = SCORE_W'(SCORE_MAX);
      end else if (sum_s < SW'(SCORE_MIN)) begin
         sat = SCORE_W'(SCORE_MIN);
      end else begin
         sat = sum_s[SCORE_W-1:0];
      end
   end

   // result item
   always_comb begin
      priority if (f_empty_ff) begin
         res.score   = '0;
         res.matched = 1'b1;
      end else if (f_fail_ff) begin
         res.score   = '1;
         res.matched = 1'b0;
      end else begin
         res.score   = sat;
         res.matched = 1'b1;
      end
   end

   assign res_valid = f_valid_ff;

endmodule

`default_nettype wire

[design/fss_rsp_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fss_rsp_fifo
// Small result queue between the scoring pipeline and the result channel;
// reports room while it can still absorb every item in flight.
// ----------------------------------------------------------------------------
module fss_rsp_fifo import fss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   input  rsp_type wr_data,
   output logic    rd_valid,
   input  logic    rd_ready,
   output rsp_type rd_data,
   output logic    has_room
);

   rsp_type           mem_ff [RSP_DEPTH];
   logic [RSP_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [RSP_CW-1:0] count_ff, count_in;
   logic              pop;

   assign rd_valid = count_ff != '0;
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign has_room = count_ff <= RSP_CW'(RSP_DEPTH - RSP_SLACK);
   assign pop      = rd_valid & rd_ready;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_valid ? wr_ptr_ff + RSP_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + RSP_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_CW'(wr_valid) - RSP_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (wr_valid) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

[design/fuzzy_subsequence_scorer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer_unit
// Fuzzy subsequence scorer: query load, greedy in-order match scoring and
// shift-and substring detection over a streamed candidate.
// ----------------------------------------------------------------------------
// Takes one item per clock while req_tready is high: each item makes a single
// pass through a row of MAX_QUERY cells, one per query character, and the
// match token and shift-and window move one cell per item. A candidate's
// score reaches the result channel after its last character passes s1_ff,
// f_valid_ff and the four-entry result queue; req_tready drops only while
// two or more results sit there untaken. Clear and append items restart the
// candidate being scored and give no result; command code 3 is ignored.
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer_unit import fss_pkg::*; #(
   parameter int MAX_QUERY = 32,
   parameter int MAX_TEXT  = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // request item
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // command [1:0], char_code [17:2], zero [23:18]
   input  logic        req_tlast,  // last character of a candidate
   // result item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // score [11:0] signed, matched [12], zero [15:13]
);

   localparam int QW = $clog2(MAX_QUERY + 1);
   localparam int PW = $clog2(MAX_TEXT);
   localparam int TW = $clog2(MAX_TEXT + 1);

   logic              acc, is_clear, is_append, is_step;
   logic [1:0]        cmd;
   logic [CHAR_W-1:0] ch;
   cell_ctrl_type     ctrl;

   logic [QW-1:0]     qlen_ff, qlen_in;
   logic [TW-1:0]     tp_ff, tp_in, tp_inc;
   logic [PW-1:0]     pos;

   s1_flags_type      s1_ff, s1_in;
   logic [PW-1:0]     s1_pos_ff;
   logic [TW-1:0]     s1_len_ff;
   logic [QW-1:0]     s1_qlen_ff;

   logic [MAX_QUERY-1:0] match_vec, tok_vec, win_vec, pf_vec, hit_vec;
   cell_stat_type        stat_arr [MAX_QUERY];

   logic    res_valid;
   rsp_type res, rd_data;

   // item decode
   assign acc       = req_tvalid & req_tready;
   assign cmd       = req_tdata[1:0];
   assign ch        = fold_char(req_tdata[17:2]);
   assign is_clear  = acc && (cmd == CMD_CLEAR);
   assign is_append = acc && (cmd == CMD_APPEND);
   assign is_step   = acc && (cmd == CMD_CHAR);

   assign ctrl.restart = is_clear | is_append;
   assign ctrl.append  = is_append;
   assign ctrl.step    = is_step;
   assign ctrl.last    = req_tlast;

   // text position, saturating
   assign pos    = (tp_ff < TW'(MAX_TEXT - 1)) ? tp_ff[PW-1:0] : PW'(MAX_TEXT - 1);
   assign tp_inc = (tp_ff < TW'(MAX_TEXT)) ? tp_ff + TW'(1) : tp_ff;

   always_comb begin
      qlen_in = qlen_ff;
      tp_in   = tp_ff;
      priority if (is_clear) begin
         qlen_in = '0;
         tp_in   = '0;
      end else if (is_append) begin
         if (qlen_ff < QW'(MAX_QUERY)) begin
            qlen_in = qlen_ff + QW'(1);
         end
         tp_in = '0;
      end else if (is_step) begin
         tp_in = req_tlast ? '0 : tp_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qlen_ff <= '0;
         tp_ff   <= '0;
      end else begin
         qlen_ff <= qlen_in;
         tp_ff   <= tp_in;
      end
   end

   // row of query cells
   for (genvar i = 0; i < MAX_QUERY; i++) begin : g_cell
      logic tok_from, win_from;
      if (i == 0) begin : g_head
         assign tok_from = 1'b0;
         assign win_from = 1'b1;
      end else begin : g_body
         assign tok_from = match_vec[i-1];
         assign win_from = win_vec[i-1];
      end
      fss_cell #(
         .IDX (i),
         .QW  (QW),
         .PW  (PW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .char_in     (ch),
         .qlen        (qlen_ff),
         .pos         (pos),
         .token_in    (tok_from),
         .window_in   (win_from),
         .token_out   (match_vec[i]),
         .token_state (tok_vec[i]),
         .window_out  (win_vec[i]),
         .stat        (stat_arr[i])
      );
   end

   // gather cell status
   always_comb begin
      for (int k = 0; k < MAX_QUERY; k++) begin
         pf_vec[k]  = stat_arr[k].prefix_fail;
         hit_vec[k] = stat_arr[k].hit;
      end
   end

   assign s1_in.restart     = ctrl.restart;
   assign s1_in.step        = is_step;
   assign s1_in.last        = req_tlast;
   assign s1_in.sep         = is_sep(ch);
   assign s1_in.match       = |match_vec;
   assign s1_in.prefix_fail = |pf_vec;
   assign s1_in.hit         = |hit_vec;

   // cell row to scoring register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else begin
         s1_ff <= s1_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pos_ff  <= pos;
      s1_len_ff  <= tp_inc;
      s1_qlen_ff <= qlen_ff;
   end

   fss_score #(
      .MAX_QUERY (MAX_QUERY),
      .MAX_TEXT  (MAX_TEXT)
   ) u_score (
      .clock     (clock),
      .reset     (reset),
      .flags     (s1_ff),
      .pos       (s1_pos_ff),
      .len       (s1_len_ff),
      .qlen      (s1_qlen_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   fss_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (res_valid),
      .wr_data  (res),
      .rd_valid (rsp_tvalid),
      .rd_ready (rsp_tready),
      .rd_data  (rd_data),
      .has_room (req_tready)
   );

   assign rsp_tdata = {3'b000, rd_data};

   // at most one cell holds the greedy match token
   a_token_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("more than one match token in the cell row");

   // no window bit beyond the loaded query
   a_window_range: assert property (@(posedge clock) disable iff (reset)
      (win_vec >> qlen_ff) == '0)
      else $error("shift-and window bit set past the query length");

   // query length never exceeds the row
   a_qlen_range: assert property (@(posedge clock) disable iff (reset)
      qlen_ff <= QW'(MAX_QUERY))
      else $error("query length beyond the cell row");

   // a last character yields a result item on the result channel
   a_result_arrives: assert property (@(posedge clock) disable iff (reset)
      (is_step && req_tlast) |-> ##3 rsp_tvalid)
      else $error("result item missing after last character");

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fuzzy subsequence scorer: drives query loads and
// candidate streams on the request channel, predicts every score in a local
// model of the greedy matcher and shift-and cells, and checks each result item.
// ----------------------------------------------------------------------------
module testbench;
   import fss_pkg::*;

   localparam int QUERY_CAP = 32;
   localparam int TEXT_CAP  = 1024;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_PRINTED = 40;
   // command code that the block must ignore
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic signed [SCORE_W-1:0] score;
      logic                      matched;
   } score_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;  // command [1:0], char_code [17:2], zero [23:18]
   logic        req_tlast = 1'b0;  // last character of a candidate
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;  // score [11:0] signed, matched [12], zero [15:13]

   fuzzy_subsequence_scorer_unit #(
      .MAX_QUERY(QUERY_CAP),
      .MAX_TEXT (TEXT_CAP)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shared bench state
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request = 0;
   int items_sent = 0;
   int results_checked = 0;
   int error_count = 0;
   int cycle_count = 0;
   score_result_type expected_scores[$];
   logic [CHAR_W-1:0] query_text[$];
   logic [CHAR_W-1:0] cand_chars[$];

   // scorer model state
   logic [CHAR_W-1:0] query_chars[QUERY_CAP];
   int query_len = 0;
   int hits, text_pos, prev_pos, first_pos, run_score;
   logic [CHAR_W-1:0] prev_char;
   bit prefix_ok, substr_seen;
   logic [QUERY_CAP-1:0] shift_cells;

   function automatic void restart_scan();
      hits = 0;
      text_pos = 0;
      prev_pos = 0;
      first_pos = 0;
      run_score = 0;
      prev_char = '0;
      prefix_ok = 1'b1;
      shift_cells = '0;
      substr_seen = 1'b0;
   endfunction

   function automatic logic [CHAR_W-1:0] fold_ascii(input logic [CHAR_W-1:0] c);
      return (c >= CH_UP_A && c <= CH_UP_Z) ? c + CH_CASE : c;
   endfunction

   // final score of a finished candidate
   function automatic score_result_type final_score();
      score_result_type r;
      int s;
      if (query_len == 0) begin
         r.score = '0;
         r.matched = 1'b1;
      end else if (hits < query_len) begin
         r.score = -1;
         r.matched = 1'b0;
      end else begin
         s = run_score - ((first_pos < LEAD_MAX) ? first_pos : LEAD_MAX) - text_pos / 8;
         if (prefix_ok && text_pos == query_len) begin
            s += EXACT_PTS;
         end else if (prefix_ok && text_pos >= query_len) begin
            s += PREFIX_PTS;
         end else if (substr_seen) begin
            s += SUBSTR_PTS;
         end
         if (s > SCORE_MAX) s = SCORE_MAX;
         if (s < SCORE_MIN) s = SCORE_MIN;
         r.score = s[SCORE_W-1:0];
         r.matched = 1'b1;
      end
      return r;
   endfunction

   // advance the scorer model by one accepted item
   task automatic advance_scorer_model(input logic [1:0] cmd, input logic [CHAR_W-1:0] raw,
                                       input logic lst);
      logic [CHAR_W-1:0] c;
      logic [QUERY_CAP-1:0] mask;
      int p, gap;
      c = fold_ascii(raw);
      case (cmd)
         CMD_CLEAR: begin
            query_len = 0;
            restart_scan();
         end
         CMD_APPEND: begin
            if (query_len < QUERY_CAP) begin
               query_chars[query_len] = c;
               query_len++;
            end
            restart_scan();
         end
         CMD_CHAR: begin
            p = (text_pos < TEXT_CAP - 1) ? text_pos : TEXT_CAP - 1;
            if (query_len > 0) begin
               // greedy in-order match
               if (hits < query_len && c == query_chars[hits]) begin
                  run_score += MATCH_PTS;
                  if (hits == 0) begin
                     first_pos = p;
                     if (p == 0) run_score += ADJ_PTS;
                  end else begin
                     if (p == prev_pos + 1) run_score += ADJ_PTS;
                     if (p > prev_pos) begin
                        gap = p - prev_pos - 1;
                        run_score -= (gap < GAP_MAX) ? gap : GAP_MAX;
                     end
                  end
                  if (p == 0 || prev_char inside {CH_SLASH, CH_UNDER, CH_DASH, CH_DOT,
                                                   CH_SPACE}) begin
                     run_score += SEP_PTS;
                  end
                  prev_pos = p;
                  hits++;
               end
               if (p < query_len && c != query_chars[p]) prefix_ok = 1'b0;
               // shift-and substring cells
               mask = '0;
               for (int i = 0; i < query_len; i++) begin
                  if (query_chars[i] == c) mask[i] = 1'b1;
               end
               shift_cells = ((shift_cells << 1) | 1) & mask;
               if (shift_cells[query_len-1]) substr_seen = 1'b1;
            end
            prev_char = c;
            if (text_pos < TEXT_CAP) text_pos++;
            if (lst) begin
               expected_scores.push_back(final_score());
               restart_scan();
            end
         end
         default: begin
         end
      endcase
   endtask

   // send one item, idling at random first, and predict once it is taken
   task automatic send_item(input logic [1:0] cmd, input logic [CHAR_W-1:0] ch,
                            input logic lst);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, ch, cmd};
      req_tlast <= lst;
      do @(posedge clock); while (!req_tready);
      if (cmd != CMD_UNUSED) items_sent++;
      advance_scorer_model(cmd, ch, lst);
   endtask

   task automatic clear_query();
      send_item(CMD_CLEAR, 16'(($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000), 1'b0);
      query_text.delete();
   endtask

   task automatic append_query_char(input logic [CHAR_W-1:0] c);
      send_item(CMD_APPEND, c, 1'($urandom_range(1)));
      query_text.push_back(c);
   endtask

   task automatic send_run(input logic [CHAR_W-1:0] c, input int n);
      repeat (n) send_item(CMD_CHAR, c, 1'b0);
   endtask

   // one mismatch line, count every one
   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want,
                  cycle_count);
      end
   endtask

   // result side: random ready, with a long counted hold-off on request
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // compare each result item with the oldest prediction
   always @(posedge clock) begin : check_results
      score_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (expected_scores.size() == 0) begin
            report_mismatch("unexpected result, score", int'($signed(rsp_tdata[11:0])), 0);
         end else begin
            want = expected_scores.pop_front();
            if (rsp_tdata[11:0] != want.score) begin
               report_mismatch("score", int'($signed(rsp_tdata[11:0])), int'(want.score));
            end
            if (rsp_tdata[12] != want.matched) begin
               report_mismatch("matched", int'(rsp_tdata[12]), int'(want.matched));
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", expected_scores.size());
         $display("FAIL fuzzy_subsequence_scorer_unit");
         $finish;
      end
   end

   // random character from a small alphabet, sometimes any code unit
   function automatic logic [CHAR_W-1:0] pick_char();
      case ($urandom_range(13))
         0: return 16'h0061;  // a
         1: return 16'h0062;  // b
         2: return 16'h0063;  // c
         3: return 16'h0041;  // A
         4: return 16'h0078;  // x
         5: return CH_SLASH;
         6: return CH_UNDER;
         7: return CH_DASH;
         8: return CH_DOT;
         9: return CH_SPACE;
         10: return 16'($urandom_range(16'h7F));
         11: return 16'($urandom_range(16'hFFFF));
         12: return 16'h005A;  // Z
         default: return 16'h0064;  // d
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] mix_case(input logic [CHAR_W-1:0] c);
      if (c >= 16'h0061 && c <= 16'h007A && $urandom_range(1) != 0) return c - CH_CASE;
      return c;
   endfunction

   task automatic load_query(input int n);
      clear_query();
      repeat (n) append_query_char(mix_case(pick_char()));
   endtask

   task automatic add_noise(input int n);
      repeat (n) cand_chars.push_back(pick_char());
   endtask

   // candidate shaped around the current query
   task automatic build_candidate();
      cand_chars.delete();
      case ($urandom_range(9))
         0, 1: foreach (query_text[i]) cand_chars.push_back(query_text[i]);
         2, 3: begin
            foreach (query_text[i]) cand_chars.push_back(query_text[i]);
            add_noise($urandom_range(1, 6));
         end
         4, 5: begin
            add_noise($urandom_range(4));
            foreach (query_text[i]) cand_chars.push_back(query_text[i]);
            add_noise($urandom_range(4));
         end
         6, 7: begin
            foreach (query_text[i]) begin
               add_noise($urandom_range(3));
               cand_chars.push_back(query_text[i]);
            end
         end
         8: add_noise($urandom_range(1, 12));
         default: foreach (query_text[i]) cand_chars.push_front(query_text[i]);
      endcase
      if (cand_chars.size() == 0) add_noise(1);
      foreach (cand_chars[i]) cand_chars[i] = mix_case(cand_chars[i]);
   endtask

   // stream the candidate, with the odd ignored or restarting item mixed in
   task automatic send_candidate();
      foreach (cand_chars[i]) begin
         if ($urandom_range(39) == 0) begin
            send_item(CMD_UNUSED, 16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)));
         end
         if ($urandom_range(59) == 0) append_query_char(pick_char());
         send_item(CMD_CHAR, cand_chars[i], i == cand_chars.size() - 1);
      end
   endtask

   // ---------------------------------------------------------------- tests

   // short hand-picked cases: empty query, bonus kinds, folding, failure
   task automatic test_directed_basics();
      send_item(CMD_CHAR, 16'h0071, 1'b1);  // empty query
      send_item(CMD_CHAR, 16'hFFFF, 1'b0);
      send_item(CMD_CHAR, 16'h0000, 1'b1);
      clear_query();
      append_query_char(16'h0041);  // A
      append_query_char(16'h0062);  // b
      // exact, both cases
      send_item(CMD_CHAR, 16'h0061, 1'b0);
      send_item(CMD_CHAR, 16'h0042, 1'b1);
      // substring after a lead character
      send_item(CMD_CHAR, 16'h0078, 1'b0);
      send_item(CMD_CHAR, 16'h0061, 1'b0);
      send_item(CMD_CHAR, 16'h0062, 1'b1);
      // prefix
      send_item(CMD_CHAR, 16'h0061, 1'b0);
      send_item(CMD_CHAR, 16'h0062, 1'b0);
      send_item(CMD_CHAR, CH_SLASH, 1'b1);
      // match after a separator with a gap
      send_item(CMD_CHAR, 16'h0061, 1'b0);
      send_item(CMD_CHAR, CH_UNDER, 1'b0);
      send_item(CMD_CHAR, 16'h0062, 1'b1);
      // out of order: no match
      send_item(CMD_CHAR, 16'h0062, 1'b0);
      send_item(CMD_CHAR, 16'h0061, 1'b1);
      // ignored command, then an append that restarts the candidate
      send_item(CMD_UNUSED, 16'h0061, 1'b1);
      send_item(CMD_CHAR, 16'h0061, 1'b0);
      append_query_char(16'hFFFF);
      send_item(CMD_CHAR, 16'h0061, 1'b0);
      send_item(CMD_CHAR, 16'h0062, 1'b0);
      send_item(CMD_CHAR, 16'hFFFF, 1'b1);
   endtask

   // appends past the query capacity, letters around the folding range
   task automatic test_query_full();
      clear_query();
      for (int i = 0; i < QUERY_CAP + 2; i++) append_query_char(16'h0040 + 16'(i));
      for (int i = 0; i < QUERY_CAP; i++) begin
         send_item(CMD_CHAR, query_text[i], i == QUERY_CAP - 1);
      end
      for (int i = 0; i <= QUERY_CAP; i++) begin
         send_item(CMD_CHAR, query_text[i], i == QUERY_CAP);
      end
      send_item(CMD_CHAR, 16'h0078, 1'b0);
      for (int i = 0; i < QUERY_CAP; i++) begin
         send_item(CMD_CHAR, mix_case(query_text[i]), i == QUERY_CAP - 1);
      end
   endtask

   // candidates longer than the position range
   task automatic test_long_candidate();
      clear_query();
      append_query_char(16'h0061);
      append_query_char(16'h0062);
      // both matches land on the saturated position
      send_run(16'h007A, TEXT_CAP + 76);
      send_item(CMD_CHAR, 16'h0061, 1'b0);
      send_item(CMD_CHAR, 16'h0062, 1'b1);
      // adjacent matches on the last two positions, then saturated length
      send_run(16'h007A, TEXT_CAP - 2);
      send_item(CMD_CHAR, 16'h0061, 1'b0);
      send_item(CMD_CHAR, 16'h0062, 1'b0);
      send_item(CMD_CHAR, 16'h007A, 1'b1);
      // long miss
      send_run(16'h0061, TEXT_CAP + 8);
      send_item(CMD_CHAR, 16'h0061, 1'b1);
   endtask

   // receiver holds off while one-character candidates keep coming
   task automatic test_result_backpressure();
      load_query(1);
      hold_request = 300;
      repeat (24) send_item(CMD_CHAR, mix_case(pick_char()), 1'b1);
   endtask

   // random queries and candidates until the item goal is reached
   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int item_goal);
      int target;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      target = items_sent + item_goal;
      while (items_sent < target) begin
         if (query_text.size() == 0 || $urandom_range(5) == 0) begin
            load_query(($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(1, 6));
         end
         build_candidate();
         send_candidate();
      end
   endtask

   // ----------------------------------------------------------------- main
   initial begin
      restart_scan();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 20;
      recv_idle_pct = 76;
      test_directed_basics();
      test_query_full();
      test_long_candidate();
      test_result_backpressure();
      test_random_traffic(20, 76, 270);
      test_random_traffic(76, 20, 270);
      test_random_traffic(0, 0, 270);
      req_tvalid <= 1'b0;

      // drain outstanding results, then a short quiet stretch
      while (expected_scores.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("run covered %0d request items and %0d scored candidates", items_sent,
               results_checked);
      $display("including query overflow, over-length text and a long result stall");
      if (error_count == 0) begin
         $display("PASS fuzzy_subsequence_scorer_unit");
      end else begin
         $display("%0d mismatches", error_count);
         $display("FAIL fuzzy_subsequence_scorer_unit");
      end
      $finish;
   end

endmodule
